// ===== rtl/mhpq_pkg.sv =====
`default_nettype none

package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_ifs.sv =====
`default_nettype none

// request word: insert a key or remove the smallest one
interface mhpq_cmd_if import mhpq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        command;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

// result word: one per request
interface mhpq_res_if import mhpq_pkg::*; #(parameter int CNT_W = 11) ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] removed_key;
  logic [STATUS_W-1:0]     status;
  logic [CNT_W-1:0]        entry_count;
  logic                    is_empty;
  logic signed [KEY_W-1:0] current_min;

  modport source (output valid, output removed_key, output status, output entry_count,
                  output is_empty, output current_min, input ready);
  modport sink   (input valid, input removed_key, input status, input entry_count,
                  input is_empty, input current_min, output ready);
endinterface

`default_nettype wire

// ===== rtl/min_heap_priority_queue_unit.sv =====
`default_nettype none

// Binary min-heap of signed 32-bit keys, CAPACITY entries deep, held in one
// synchronous RAM (one write port, two registered read ports); the root is
// mirrored in a register so the minimum is always at hand. One request word
// is taken at a time and gives one result word. An insert climbs from the
// new last slot towards the root, and a remove moves the last key to the root
// and sinks it; each level costs one RAM read step (S_UP or S_DN) and one
// compare/write step (S_UP_CMP or S_DN_CMP). The longest request is an insert
// that climbs from the last slot to the root. An error (remove from an empty
// heap, insert into a full heap) and a remove of the only key go straight to
// S_FIN with the RAM untouched. The next request is taken only after the
// result is loaded, and not while the output register waits on a stalled
// receiver. The result interface must be built with
// CNT_W = $clog2(CAPACITY + 1).
module min_heap_priority_queue_unit import mhpq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mhpq_cmd_if.sink   cmd,
  mhpq_res_if.source res
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = AW + 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP     = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_DN_LD  = 7'b0001000,
    S_DN     = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [AW-1:0]    pos, pos_next;
  key_t             hold_key, hold_key_next;
  logic [CNT_W-1:0] count, count_next;
  key_t             removed, removed_next;
  status_t          status, status_next;
  logic             right_ok, right_ok_next;
  key_t             root_key;

  key_t             mem [CAPACITY];
  key_t             rd_a, rd_b;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  key_t             wr_data;

  logic [AW-1:0]    parent;
  logic [CW-1:0]    child_l, child_r, count_ext;
  logic [CNT_W-1:0] count_m1;
  logic             take_l, take_r;

  assign parent    = (pos - AW'(1)) >> 1;
  assign child_l   = {1'b0, pos, 1'b1};
  assign child_r   = child_l + CW'(1);
  assign count_ext = CW'(count);
  assign count_m1  = count - CNT_W'(1);

  // pick the smaller child; left wins ties, node wins ties with a child
  always_comb begin
    take_l = rd_a < hold_key;
    take_r = right_ok && (take_l ? (rd_b < rd_a) : (rd_b < hold_key));
  end

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    hold_key_next = hold_key;
    count_next    = count;
    removed_next  = removed;
    status_next   = status;
    right_ok_next = right_ok;
    rd_addr_a     = count_m1[AW-1:0];
    rd_addr_b     = child_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = hold_key;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          removed_next = '0;
          status_next  = ST_OK;
          if (cmd.command == CMD_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next  = S_FIN;
            end else begin
              pos_next      = count[AW-1:0];
              hold_key_next = cmd.key;
              count_next    = count + CNT_W'(1);
              state_next    = S_UP;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_FIN;
            end else begin
              removed_next = root_key;
              count_next   = count_m1;
              // last entry is read here and lands in rd_a next cycle
              state_next   = (count_m1 == '0) ? S_FIN : S_DN_LD;
            end
          end
        end
      end
      S_UP: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          rd_addr_a  = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (hold_key < rd_a) begin
          // move the parent down into the hole and climb
          wr_data    = rd_a;
          pos_next   = parent;
          state_next = S_UP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_LD: begin
        hold_key_next = rd_a;
        pos_next      = '0;
        state_next    = S_DN;
      end
      S_DN: begin
        if (child_l >= count_ext) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          rd_addr_a     = child_l[AW-1:0];
          rd_addr_b     = child_r[AW-1:0];
          right_ok_next = child_r < count_ext;
          state_next    = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data    = rd_b;
          pos_next   = child_r[AW-1:0];
          state_next = S_DN;
        end else if (take_l) begin
          wr_data    = rd_a;
          pos_next   = child_l[AW-1:0];
          state_next = S_DN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!res.valid || res.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    hold_key <= hold_key_next;
    removed  <= removed_next;
    status   <= status_next;
    right_ok <= right_ok_next;
    if (wr_en && wr_addr == '0) begin
      root_key <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_FIN && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!res.valid || res.ready)) begin
      res.removed_key <= removed;
      res.status      <= status;
      res.entry_count <= count;
      res.is_empty    <= (count == '0);
      res.current_min <= (count == '0) ? key_t'(0) : root_key;
    end
  end

endmodule

`default_nettype wire
